### hw/rtl/becol_pkg.sv
package becol_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int COL_W = 12;
  localparam logic [COL_W-1:0] COL_TOP =
    (MAX_COLUMNS > 4096) ? 12'hFFF : COL_W'(MAX_COLUMNS - 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

  localparam int SUM_W = 18;
  localparam int NUM_W = 26;
  localparam int QUO_W = 8;

  typedef struct packed {
    logic [7:0] left_amplitude;
    logic [7:0] right_amplitude;
    logic [7:0] first_low;
    logic [7:0] first_mid;
    logic [7:0] first_high;
    logic [7:0] second_low;
    logic [7:0] second_mid;
    logic [7:0] second_high;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [7:0] upper_height;
    logic [7:0] upper_red;
    logic [7:0] upper_green;
    logic [7:0] upper_blue;
    logic       upper_drawn;
    logic [7:0] lower_height;
    logic [7:0] lower_red;
    logic [7:0] lower_green;
    logic [7:0] lower_blue;
    logic       lower_drawn;
    logic [7:0] amplitude_peak;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mix;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

### hw/rtl/becol_if.sv
interface becol_in_if (input logic clk);
  logic valid;
  logic ready;
  becol_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface becol_out_if (input logic clk);
  logic valid;
  logic ready;
  becol_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/becol_ctrl.sv
module becol_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  becol_pkg::sts_t   sts,
  output becol_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MIX  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic div_busy;

  assign div_busy = (state_r == S_DIV);
  // accept while idle; the output register holds the previous word
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mix, cmd.div_step, cmd.finish}))
    else $error("more than one phase command");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_MIX)
    else $error("load did not advance to mix");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish did not raise out valid");
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> div_busy)
    else $error("divider stepped outside divide phase");

endmodule

### hw/rtl/becol_dp.sv
module becol_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [becol_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [becol_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  becol_pkg::in_word_t                 in_data,
  input  becol_pkg::cmd_t                     cmd,
  output becol_pkg::sts_t                     sts,
  output becol_pkg::out_word_t                out_data
);

  localparam int SW = becol_pkg::SUM_W;
  localparam int NW = becol_pkg::NUM_W;

  logic [23:0] low_c_r, mid_c_r, high_c_r;
  becol_pkg::in_word_t in_r;
  logic [becol_pkg::COL_W-1:0] col_r;
  logic [7:0] peak_r, peak_nxt;
  logic [SW-1:0] m_r [2];
  logic [NW-1:0] rem_r [6];
  logic [7:0] q_r [6];
  logic [2:0] bit_r;
  becol_pkg::out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_c_r <= 24'hFF0000;
      mid_c_r <= 24'h00FF00;
      high_c_r <= 24'h0000FF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        becol_pkg::REG_LOW:  low_c_r <= cfg_data;
        becol_pkg::REG_MID:  mid_c_r <= cfg_data;
        becol_pkg::REG_HIGH: high_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] mixc(input logic [7:0] lo, input logic [7:0] mi,
      input logic [7:0] hi, input logic [7:0] cl, input logic [7:0] cm,
      input logic [7:0] ch);
    mixc = SW'(lo) * SW'(cl) + SW'(mi) * SW'(cm) + SW'(hi) * SW'(ch);
  endfunction

  function automatic logic [SW-1:0] max3(input logic [SW-1:0] a,
      input logic [SW-1:0] b, input logic [SW-1:0] c);
    logic [SW-1:0] t;
    t = (b > a) ? b : a;
    max3 = (c > t) ? c : t;
  endfunction

  logic [SW-1:0] s_mix [6];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s_mix[c] = mixc(in_r.first_low, in_r.first_mid, in_r.first_high,
        low_c_r[16-8*c +: 8], mid_c_r[16-8*c +: 8], high_c_r[16-8*c +: 8]);
      s_mix[c+3] = mixc(in_r.second_low, in_r.second_mid, in_r.second_high,
        low_c_r[16-8*c +: 8], mid_c_r[16-8*c +: 8], high_c_r[16-8*c +: 8]);
    end
  end

  assign peak_nxt = (in_data.left_amplitude > peak_r || in_data.right_amplitude > peak_r)
    ? ((in_data.left_amplitude > in_data.right_amplitude)
       ? in_data.left_amplitude : in_data.right_amplitude)
    : peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      peak_r <= '0;
    end else begin
      if (cmd.load) peak_r <= peak_nxt;
      if (cmd.finish && col_r < becol_pkg::COL_TOP) col_r <= col_r + 1'b1;
    end
  end

  // restoring division, one quotient bit per lane per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.mix) begin
      m_r[0] <= max3(s_mix[0], s_mix[1], s_mix[2]);
      m_r[1] <= max3(s_mix[3], s_mix[4], s_mix[5]);
    end
    if (cmd.div_start) begin
      bit_r <= 3'd7;
      for (int i = 0; i < 6; i++) begin
        rem_r[i] <= NW'({s_mix[i], 8'h00}) - NW'(s_mix[i])
          + NW'(max3(s_mix[3*(i/3)], s_mix[3*(i/3)+1], s_mix[3*(i/3)+2]) >> 1);
        q_r[i] <= '0;
      end
    end
    if (cmd.div_step) begin
      bit_r <= bit_r - 1'b1;
      for (int i = 0; i < 6; i++) begin
        logic [NW-1:0] d;
        d = NW'(m_r[i/3]) << bit_r;
        if (rem_r[i] >= d) begin
          rem_r[i] <= rem_r[i] - d;
          q_r[i][bit_r] <= 1'b1;
        end
      end
    end
    if (cmd.finish) begin
      out_r.column <= col_r;
      out_r.upper_height <= in_r.left_amplitude;
      out_r.lower_height <= in_r.right_amplitude;
      out_r.upper_drawn <= m_r[0] != '0;
      out_r.lower_drawn <= m_r[1] != '0;
      out_r.upper_red <= (m_r[0] != '0) ? q_r[0] : '0;
      out_r.upper_green <= (m_r[0] != '0) ? q_r[1] : '0;
      out_r.upper_blue <= (m_r[0] != '0) ? q_r[2] : '0;
      out_r.lower_red <= (m_r[1] != '0) ? q_r[3] : '0;
      out_r.lower_green <= (m_r[1] != '0) ? q_r[4] : '0;
      out_r.lower_blue <= (m_r[1] != '0) ? q_r[5] : '0;
      out_r.amplitude_peak <= peak_r;
    end
  end

  assign sts.div_last = (bit_r == 3'd0);
  assign out_data = out_r;

endmodule

### hw/rtl/band_energy_rgb_colorizer.sv
// channel | dir | payload                         | handshake
// in_     | in  | becol_pkg::in_word_t (8 fields)  | valid/ready
// out_    | out | becol_pkg::out_word_t (12 fields)| valid/ready
// cfg_    | in  | index 2b, data 24b               | write enable only
// Each word passes through accept, mix, eight quotient-bit steps of the six
// parallel restoring dividers, then the output register load.
// Reset (rst_n low, synchronous) restores the default colors, clears the
// column counter and running peak, and drops out_valid.
// A stalled output holds its word; a new input word is still accepted and
// worked on while the previous result waits.
module band_energy_rgb_colorizer (
  input  logic                             clk,
  input  logic                             rst_n,
  becol_in_if.sink                         in_ch,
  becol_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [becol_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [becol_pkg::CFG_DATA_W-1:0] cfg_data
);

  becol_pkg::cmd_t cmd;
  becol_pkg::sts_t sts;

  // sequencer: one word in flight through mix and divide
  becol_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  // datapath: color registers, mix sums, dividers, output register
  becol_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_data(in_ch.data), .cmd, .sts, .out_data(out_ch.data)
  );

endmodule

### tb/becol_checker.sv
module becol_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  becol_pkg::in_word_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  becol_pkg::out_word_t             out_data,
  input  logic                             cfg_we,
  input  logic [becol_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [becol_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] low_rgb, mid_rgb, high_rgb;
  logic [becol_pkg::COL_W-1:0] next_column;
  logic [7:0] peak_so_far;
  becol_pkg::out_word_t expected_words[$];

  // Mix one half through the color matrix and normalize to 255.
  function automatic logic [24:0] color_half(logic [7:0] lo, logic [7:0] mi, logic [7:0] hi);
    logic [31:0] s[3];
    logic [31:0] m;
    logic [24:0] r;
    for (int c = 0; c < 3; c++) begin
      s[c] = lo * low_rgb[16-8*c +: 8] + mi * mid_rgb[16-8*c +: 8]
           + hi * high_rgb[16-8*c +: 8];
    end
    m = s[0];
    if (s[1] > m) m = s[1];
    if (s[2] > m) m = s[2];
    r = '0;
    if (m != 0) begin
      for (int c = 0; c < 3; c++) r[24-8*c -: 8] = 8'((s[c] * 255 + m / 2) / m);
      r[0] = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    becol_pkg::out_word_t e, got;
    logic [24:0] u, l;
    if (!rst_n) begin
      low_rgb <= 24'hFF0000;
      mid_rgb <= 24'h00FF00;
      high_rgb <= 24'h0000FF;
      next_column <= '0;
      peak_so_far <= '0;
      expected_words.delete();
      fail_count <= 0;
      pending <= 0;
      words_checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          becol_pkg::REG_LOW:  low_rgb <= cfg_data;
          becol_pkg::REG_MID:  mid_rgb <= cfg_data;
          becol_pkg::REG_HIGH: high_rgb <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        e.column = next_column;
        e.upper_height = in_data.left_amplitude;
        e.lower_height = in_data.right_amplitude;
        u = color_half(in_data.first_low, in_data.first_mid, in_data.first_high);
        l = color_half(in_data.second_low, in_data.second_mid, in_data.second_high);
        {e.upper_red, e.upper_green, e.upper_blue, e.upper_drawn} = u;
        {e.lower_red, e.lower_green, e.lower_blue, e.lower_drawn} = l;
        e.amplitude_peak = peak_so_far;
        if (in_data.left_amplitude > e.amplitude_peak) e.amplitude_peak = in_data.left_amplitude;
        if (in_data.right_amplitude > e.amplitude_peak) e.amplitude_peak = in_data.right_amplitude;
        peak_so_far <= e.amplitude_peak;
        if (next_column < becol_pkg::COL_TOP) next_column <= next_column + 1'b1;
        expected_words.push_back(e);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (got !== e) begin
            if (fail_count < 10)
              $display("mismatch at column %0d: expected %h got %h", e.column, e, got);
            fail_count <= fail_count + 1;
          end
          words_checked <= words_checked + 1;
        end
      end
      pending <= expected_words.size();
    end
  end
endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the last register; writes to it are ignored
  localparam logic [becol_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [becol_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [becol_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, words_checked;
  int words_sent;
  int cycle_count;
  bit long_hold;

  becol_in_if in_ch (clk);
  becol_out_if out_ch (clk);

  band_energy_rgb_colorizer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  becol_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: the slowest run is about 900 words plus the long hold; the limit
  // allows many times that.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls before each word, calm stretches with
  // none, and one long hold so the block fills up and backs up its input.
  initial begin
    int wait_cycles;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = (words_sent % 200 < 40) ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Hand one word to the block, after a random gap unless no_gap is set.
  task automatic send_word(becol_pkg::in_word_t w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drain all expected words, then hold idle past the block's latency.
  task automatic drain_then_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One write, after which the enable is dropped again.
  task automatic write_reg(logic [becol_pkg::CFG_IDX_W-1:0] idx,
      logic [becol_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic becol_pkg::in_word_t random_word();
    becol_pkg::in_word_t w;
    w = becol_pkg::in_word_t'({$urandom, $urandom});
    // Bias some halves toward zero energy to reach the undrawn case.
    if ($urandom_range(0, 9) == 0) {w.first_low, w.first_mid, w.first_high} = '0;
    if ($urandom_range(0, 9) == 0) {w.second_low, w.second_mid, w.second_high} = '0;
    if ($urandom_range(0, 7) == 0) w.first_mid = 8'($urandom_range(0, 3));
    return w;
  endfunction

  initial begin
    becol_pkg::in_word_t w;
    logic [becol_pkg::CFG_DATA_W-1:0] palette[3];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    words_sent = 0;
    long_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset colors, field extremes, zero mixes.
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word({8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_word({8'd255, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1}, 1'b0);
    send_word({8'd17, 8'd3, 8'd0, 8'd0, 8'd255, 8'd2, 8'd3, 8'd4}, 1'b0);
    send_word({8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55}, 1'b0);
    send_word({8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa}, 1'b0);
    drain_then_idle();

    // Extreme palettes: all black, all white, and odd mixes; unused index ignored.
    write_reg(becol_pkg::REG_LOW, 24'h000000);
    write_reg(becol_pkg::REG_MID, 24'h000000);
    write_reg(becol_pkg::REG_HIGH, 24'h000000);
    send_word('1, 1'b0);
    drain_then_idle();
    write_reg(becol_pkg::REG_LOW, 24'hFFFFFF);
    write_reg(becol_pkg::REG_MID, 24'hFFFFFF);
    write_reg(becol_pkg::REG_HIGH, 24'hFFFFFF);
    write_reg(REG_UNUSED, 24'h123456);
    send_word('1, 1'b0);
    send_word({8'd9, 8'd9, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b0);
    drain_then_idle();
    write_reg(becol_pkg::REG_LOW, 24'h010203);
    write_reg(becol_pkg::REG_MID, 24'h800001);
    write_reg(becol_pkg::REG_HIGH, 24'h00FF7F);
    send_word({8'd1, 8'd2, 8'd255, 8'd1, 8'd0, 8'd0, 8'd1, 8'd255}, 1'b0);
    drain_then_idle();

    // Random phases, each under a fresh palette.
    for (int phase = 0; phase < 6; phase++) begin
      for (int r = 0; r < 3; r++) palette[r] = becol_pkg::CFG_DATA_W'($urandom);
      write_reg(becol_pkg::REG_LOW, palette[0]);
      write_reg(becol_pkg::REG_MID, palette[1]);
      write_reg(becol_pkg::REG_HIGH, palette[2]);
      for (int n = 0; n < 150; n++) begin
        if (phase == 2 && n == 20) long_hold = 1'b1;
        send_word(random_word(), (n % 50) < 10);
      end
      drain_then_idle();
    end

    $display("%0d words sent, %0d checked, palettes from black to white and random",
             words_sent, words_checked);
    $display("output held off for 300 cycles while input kept coming");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
